/* hdl/mp2d_pkg.sv */
// Shared constants and types for the streaming 2-D max pooling core.
package mp2d_pkg;

    // Default sizing of the core
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_WINDOW   = 4;
    localparam int DEF_DATA_WIDTH   = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam int HEIGHT_W   = 9;
    localparam int WIDTH_W    = 9;
    localparam int CHANNELS_W = 5;
    localparam int WINDOW_W   = 3;
    localparam int STEP_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE     = 3'd4;

    localparam logic [HEIGHT_W-1:0]   RST_IMAGE_HEIGHT  = 9'd8;
    localparam logic [WIDTH_W-1:0]    RST_IMAGE_WIDTH   = 9'd8;
    localparam logic [CHANNELS_W-1:0] RST_CHANNEL_COUNT = 5'd1;
    localparam logic [WINDOW_W-1:0]   RST_WINDOW_SIZE   = 3'd2;
    localparam logic [STEP_W-1:0]     RST_STEP_SIZE     = 3'd2;

    // Output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    // Sequencer: rebuild window phase counters, then stream
    typedef enum logic [1:0] {
        ST_INIT,
        ST_WALK,
        ST_RUN
    } ctl_state_t;

endpackage

/* hdl/max_pool_2d_stream_core.sv */
// Streaming 2-D max pooling core: window memory, line memory, output queue.
//
// Samples enter in raster order (row, column, channel innermost) and the core
// sustains one sample per clock while not rebuilding and while the output
// queue has room. A result passes the stage 1 and stage 2 registers into the
// output queue after the sample that completes its window is taken and leaves
// in raster order with channel innermost; tlast marks the last pooled value of
// an image. The per-channel horizontal window sits in one memory row per
// channel and the horizontal maxima in a line memory addressed by column and
// channel; each sample does one read-modify-write of each, back to back, with
// write forwarding (the line memory is written from column window-1 on). After
// reset and after every configuration write the core holds tready low while
// it rebuilds its window phase counters. Neither memory is cleared.
module max_pool_2d_stream_core #(
    parameter int MAX_HEIGHT   = mp2d_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH    = mp2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_CHANNELS = mp2d_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_WINDOW   = mp2d_pkg::DEF_MAX_WINDOW,
    parameter int DATA_WIDTH   = mp2d_pkg::DEF_DATA_WIDTH,
    localparam int TDATA_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mp2d_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mp2d_pkg::CFG_DATA_W-1:0]    cfg_data,
    // sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [TDATA_W-1:0]                 s_axis_tdata,  // [DATA_WIDTH-1:0] sample_value
    input  logic [0:0]                         s_axis_tuser,  // [0] frame_start
    // pooled stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [TDATA_W-1:0]                 m_axis_tdata,  // [DATA_WIDTH-1:0] pooled_value
    output logic                               m_axis_tlast
);

    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CCW  = $clog2(MAX_CHANNELS + 1);
    localparam int KW   = $clog2(MAX_WINDOW + 1);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CHW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NRW  = $clog2(MAX_HEIGHT + MAX_WINDOW + 1);
    localparam int NCW  = $clog2(MAX_WIDTH + MAX_WINDOW + 1);
    localparam int ROW_BITS   = MAX_WINDOW * DATA_WIDTH;
    localparam int LINE_AW    = COLW + CHW;
    localparam int LINE_DEPTH = 1 << LINE_AW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mp2d_pkg::HEIGHT_W-1:0]   height_reg;
    logic [mp2d_pkg::WIDTH_W-1:0]    width_reg;
    logic [mp2d_pkg::CHANNELS_W-1:0] channels_reg;
    logic [mp2d_pkg::WINDOW_W-1:0]   window_reg;
    logic [mp2d_pkg::STEP_W-1:0]     step_reg;
    logic                            cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg   <= mp2d_pkg::RST_IMAGE_HEIGHT;
            width_reg    <= mp2d_pkg::RST_IMAGE_WIDTH;
            channels_reg <= mp2d_pkg::RST_CHANNEL_COUNT;
            window_reg   <= mp2d_pkg::RST_WINDOW_SIZE;
            step_reg     <= mp2d_pkg::RST_STEP_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mp2d_pkg::REG_IMAGE_HEIGHT:  height_reg   <= cfg_data[mp2d_pkg::HEIGHT_W-1:0];
                mp2d_pkg::REG_IMAGE_WIDTH:   width_reg    <= cfg_data[mp2d_pkg::WIDTH_W-1:0];
                mp2d_pkg::REG_CHANNEL_COUNT: channels_reg <= cfg_data[mp2d_pkg::CHANNELS_W-1:0];
                mp2d_pkg::REG_WINDOW_SIZE:   window_reg   <= cfg_data[mp2d_pkg::WINDOW_W-1:0];
                mp2d_pkg::REG_STEP_SIZE:     step_reg     <= cfg_data[mp2d_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped working values
    logic [HW-1:0]  h_eff;
    logic [WW-1:0]  w_eff;
    logic [CCW-1:0] c_eff;
    logic [KW-1:0]  k_eff;
    logic [KW-1:0]  s_eff;
    logic [NRW-1:0] km1_r;
    logic [NCW-1:0] km1_c;

    assign h_eff = (height_reg == '0) ? HW'(1) :
                   (32'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_reg);
    assign w_eff = (width_reg == '0) ? WW'(1) :
                   (32'(width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_reg);
    assign c_eff = (channels_reg == '0) ? CCW'(1) :
                   (32'(channels_reg) > MAX_CHANNELS) ? CCW'(MAX_CHANNELS) : CCW'(channels_reg);
    assign k_eff = (window_reg == '0) ? KW'(1) :
                   (32'(window_reg) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(window_reg);
    assign s_eff = (step_reg == '0) ? KW'(1) :
                   (32'(step_reg) > MAX_WINDOW) ? KW'(MAX_WINDOW) : KW'(step_reg);
    assign km1_r = NRW'(k_eff) - NRW'(1);
    assign km1_c = NCW'(k_eff) - NCW'(1);

    // ------------------------------------------------------------------
    // Position counters and window phase
    // nrow/ncol hold the next row/column at which a window ends;
    // rslot/cslot are row and column modulo the window size.
    // ------------------------------------------------------------------
    mp2d_pkg::ctl_state_t state_reg, state_next;

    logic [RW-1:0]   row_reg, row_next;
    logic [COLW-1:0] col_reg, col_next;
    logic [CHW-1:0]  ch_reg, ch_next;
    logic [SW-1:0]   rslot_reg, rslot_next;
    logic [SW-1:0]   cslot_reg, cslot_next;
    logic [NRW-1:0]  nrow_reg, nrow_next;
    logic [NCW-1:0]  ncol_reg, ncol_next;
    logic [RW-1:0]   walk_row_reg, walk_row_next;
    logic [COLW-1:0] walk_col_reg, walk_col_next;

    logic [mp2d_pkg::OQ_CW-1:0] oq_count_reg;
    logic                       s1_valid_reg;
    logic                       s2_valid_reg;
    logic [mp2d_pkg::OQ_CW-1:0] occupancy;
    logic                       in_accept;

    assign occupancy = oq_count_reg + mp2d_pkg::OQ_CW'(s1_valid_reg)
                       + mp2d_pkg::OQ_CW'(s2_valid_reg);
    assign s_axis_tready = (state_reg == mp2d_pkg::ST_RUN)
                           && (occupancy < mp2d_pkg::OQ_CW'(mp2d_pkg::OQ_DEPTH));
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // position of the current beat after a frame restart
    logic            restart;
    logic [RW-1:0]   cur_row;
    logic [COLW-1:0] cur_col;
    logic [CHW-1:0]  cur_ch;
    logic [SW-1:0]   cur_rslot, cur_cslot;
    logic [NRW-1:0]  cur_nrow;
    logic [NCW-1:0]  cur_ncol;
    logic            row_hit, col_hit, line_wen, emit, last;
    logic            ch_wrap, col_wrap, row_wrap;

    assign restart = s_axis_tuser[0]
                     || (HW'(row_reg) >= h_eff)
                     || (WW'(col_reg) >= w_eff)
                     || (CCW'(ch_reg) >= c_eff);
    assign cur_row   = restart ? '0 : row_reg;
    assign cur_col   = restart ? '0 : col_reg;
    assign cur_ch    = restart ? '0 : ch_reg;
    assign cur_rslot = restart ? '0 : rslot_reg;
    assign cur_cslot = restart ? '0 : cslot_reg;
    assign cur_nrow  = restart ? km1_r : nrow_reg;
    assign cur_ncol  = restart ? km1_c : ncol_reg;

    assign row_hit  = NRW'(cur_row) == cur_nrow;
    assign col_hit  = NCW'(cur_col) == cur_ncol;
    assign line_wen = NCW'(cur_col) >= km1_c;
    assign emit     = row_hit && col_hit;
    assign last     = emit
                      && (NRW'(cur_row) + NRW'(s_eff) >= NRW'(h_eff))
                      && (NCW'(cur_col) + NCW'(s_eff) >= NCW'(w_eff))
                      && (CCW'(cur_ch) + CCW'(1) == c_eff);

    assign ch_wrap  = CCW'(cur_ch) + CCW'(1) >= c_eff;
    assign col_wrap = WW'(cur_col) + WW'(1) >= w_eff;
    assign row_wrap = HW'(cur_row) + HW'(1) >= h_eff;

    // phase advance, shared by streaming and the rebuild walk
    logic            run_mode;
    logic [RW-1:0]   sr_pos;
    logic [COLW-1:0] sc_pos;
    logic [SW-1:0]   sr_slot, sc_slot, sr_slot_adv, sc_slot_adv;
    logic [NRW-1:0]  sr_next, sr_next_adv;
    logic [NCW-1:0]  sc_next, sc_next_adv;

    assign run_mode = state_reg == mp2d_pkg::ST_RUN;
    assign sr_pos   = run_mode ? cur_row   : walk_row_reg;
    assign sr_slot  = run_mode ? cur_rslot : rslot_reg;
    assign sr_next  = run_mode ? cur_nrow  : nrow_reg;
    assign sc_pos   = run_mode ? cur_col   : walk_col_reg;
    assign sc_slot  = run_mode ? cur_cslot : cslot_reg;
    assign sc_next  = run_mode ? cur_ncol  : ncol_reg;

    assign sr_slot_adv = (KW'(sr_slot) == k_eff - KW'(1)) ? '0 : sr_slot + SW'(1);
    assign sc_slot_adv = (KW'(sc_slot) == k_eff - KW'(1)) ? '0 : sc_slot + SW'(1);
    assign sr_next_adv = (NRW'(sr_pos) == sr_next) ? sr_next + NRW'(s_eff) : sr_next;
    assign sc_next_adv = (NCW'(sc_pos) == sc_next) ? sc_next + NCW'(s_eff) : sc_next;

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        ch_next       = ch_reg;
        rslot_next    = rslot_reg;
        cslot_next    = cslot_reg;
        nrow_next     = nrow_reg;
        ncol_next     = ncol_reg;
        walk_row_next = walk_row_reg;
        walk_col_next = walk_col_reg;

        unique case (state_reg)
            mp2d_pkg::ST_INIT:
            begin
                rslot_next    = '0;
                cslot_next    = '0;
                nrow_next     = km1_r;
                ncol_next     = km1_c;
                walk_row_next = '0;
                walk_col_next = '0;
                state_next    = mp2d_pkg::ST_WALK;
            end
            mp2d_pkg::ST_WALK:
            begin
                if (walk_col_reg != col_reg)
                begin
                    cslot_next    = sc_slot_adv;
                    ncol_next     = sc_next_adv;
                    walk_col_next = walk_col_reg + COLW'(1);
                end
                if (walk_row_reg != row_reg)
                begin
                    rslot_next    = sr_slot_adv;
                    nrow_next     = sr_next_adv;
                    walk_row_next = walk_row_reg + RW'(1);
                end
                if ((walk_col_reg == col_reg) && (walk_row_reg == row_reg))
                    state_next = mp2d_pkg::ST_RUN;
            end
            mp2d_pkg::ST_RUN:
            begin
                if (in_accept)
                begin
                    row_next   = cur_row;
                    col_next   = cur_col;
                    rslot_next = cur_rslot;
                    cslot_next = cur_cslot;
                    nrow_next  = cur_nrow;
                    ncol_next  = cur_ncol;
                    ch_next    = cur_ch + CHW'(1);
                    if (ch_wrap)
                    begin
                        ch_next = '0;
                        if (col_wrap)
                        begin
                            col_next   = '0;
                            cslot_next = '0;
                            ncol_next  = km1_c;
                            if (row_wrap)
                            begin
                                row_next   = '0;
                                rslot_next = '0;
                                nrow_next  = km1_r;
                            end
                            else
                            begin
                                row_next   = cur_row + RW'(1);
                                rslot_next = sr_slot_adv;
                                nrow_next  = sr_next_adv;
                            end
                        end
                        else
                        begin
                            col_next   = cur_col + COLW'(1);
                            cslot_next = sc_slot_adv;
                            ncol_next  = sc_next_adv;
                        end
                    end
                end
            end
            default: state_next = mp2d_pkg::ST_INIT;
        endcase

        // new geometry: rebuild phase from scratch
        if (cfg_write)
            state_next = mp2d_pkg::ST_INIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mp2d_pkg::ST_INIT;
            row_reg      <= '0;
            col_reg      <= '0;
            ch_reg       <= '0;
            rslot_reg    <= '0;
            cslot_reg    <= '0;
            nrow_reg     <= '0;
            ncol_reg     <= '0;
            walk_row_reg <= '0;
            walk_col_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            ch_reg       <= ch_next;
            rslot_reg    <= rslot_next;
            cslot_reg    <= cslot_next;
            nrow_reg     <= nrow_next;
            ncol_reg     <= ncol_next;
            walk_row_reg <= walk_row_next;
            walk_col_reg <= walk_col_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: horizontal max via window memory (one row per channel)
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0]   win_mem [MAX_CHANNELS];
    logic [ROW_BITS-1:0]   win_rdata_reg;
    logic                  win_fwd_valid_reg;
    logic [CHW-1:0]        win_fwd_addr_reg;
    logic [ROW_BITS-1:0]   win_fwd_data_reg;

    logic [DATA_WIDTH-1:0] s1_x_reg;
    logic [CHW-1:0]        s1_ch_reg;
    logic [COLW-1:0]       s1_col_reg;
    logic [SW-1:0]         s1_cslot_reg;
    logic [SW-1:0]         s1_rslot_reg;
    logic                  s1_lwen_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_accept;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg      <= s_axis_tdata[DATA_WIDTH-1:0];
            s1_ch_reg     <= cur_ch;
            s1_col_reg    <= cur_col;
            s1_cslot_reg  <= cur_cslot;
            s1_rslot_reg  <= cur_rslot;
            s1_lwen_reg   <= line_wen;
            s1_emit_reg   <= emit;
            s1_last_reg   <= last;
            win_rdata_reg <= win_mem[cur_ch];
        end
    end

    logic [ROW_BITS-1:0]          win_row;
    logic [ROW_BITS-1:0]          win_row_mod;
    logic signed [DATA_WIDTH-1:0] hmax;

    always_comb
    begin
        logic signed [DATA_WIDTH-1:0] cand;
        win_row = (win_fwd_valid_reg && (win_fwd_addr_reg == s1_ch_reg))
                  ? win_fwd_data_reg : win_rdata_reg;
        win_row_mod = win_row;
        win_row_mod[s1_cslot_reg * DATA_WIDTH +: DATA_WIDTH] = s1_x_reg;
        hmax = $signed(s1_x_reg);
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cand = $signed(win_row_mod[i * DATA_WIDTH +: DATA_WIDTH]);
            if ((KW'(i) < k_eff) && (cand > hmax))
                hmax = cand;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            win_mem[s1_ch_reg] <= win_row_mod;
        win_fwd_addr_reg <= s1_ch_reg;
        win_fwd_data_reg <= win_row_mod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_fwd_valid_reg <= 1'b0;
        else
            win_fwd_valid_reg <= s1_valid_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: vertical max via line memory (column, channel)
    // ------------------------------------------------------------------
    logic [ROW_BITS-1:0]   line_mem [LINE_DEPTH];
    logic [ROW_BITS-1:0]   line_rdata_reg;
    logic                  line_fwd_valid_reg;
    logic [LINE_AW-1:0]    line_fwd_addr_reg;
    logic [ROW_BITS-1:0]   line_fwd_data_reg;

    logic [DATA_WIDTH-1:0] s2_hmax_reg;
    logic [LINE_AW-1:0]    s2_addr_reg;
    logic [SW-1:0]         s2_rslot_reg;
    logic                  s2_lwen_reg;
    logic                  s2_emit_reg;
    logic                  s2_last_reg;
    logic [LINE_AW-1:0]    s1_line_addr;

    assign s1_line_addr = {s1_col_reg, s1_ch_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_hmax_reg    <= hmax;
            s2_addr_reg    <= s1_line_addr;
            s2_rslot_reg   <= s1_rslot_reg;
            s2_lwen_reg    <= s1_lwen_reg;
            s2_emit_reg    <= s1_emit_reg;
            s2_last_reg    <= s1_last_reg;
            line_rdata_reg <= line_mem[s1_line_addr];
        end
    end

    logic [ROW_BITS-1:0]          line_row;
    logic [ROW_BITS-1:0]          line_row_mod;
    logic signed [DATA_WIDTH-1:0] vmax;

    always_comb
    begin
        logic signed [DATA_WIDTH-1:0] cand;
        line_row = (line_fwd_valid_reg && (line_fwd_addr_reg == s2_addr_reg))
                   ? line_fwd_data_reg : line_rdata_reg;
        line_row_mod = line_row;
        line_row_mod[s2_rslot_reg * DATA_WIDTH +: DATA_WIDTH] = s2_hmax_reg;
        vmax = $signed(s2_hmax_reg);
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cand = $signed(line_row_mod[i * DATA_WIDTH +: DATA_WIDTH]);
            if ((KW'(i) < k_eff) && (cand > vmax))
                vmax = cand;
        end
    end

    logic line_write;
    assign line_write = s2_valid_reg && s2_lwen_reg;

    always_ff @(posedge clk)
    begin
        if (line_write)
            line_mem[s2_addr_reg] <= line_row_mod;
        line_fwd_addr_reg <= s2_addr_reg;
        line_fwd_data_reg <= line_row_mod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_fwd_valid_reg <= 1'b0;
        else
            line_fwd_valid_reg <= line_write;
    end

    // ------------------------------------------------------------------
    // Output queue; tready above reserves room for beats in flight
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0]      oq_data_reg [mp2d_pkg::OQ_DEPTH];
    logic                       oq_last_reg [mp2d_pkg::OQ_DEPTH];
    logic [mp2d_pkg::OQ_AW-1:0] oq_wptr_reg;
    logic [mp2d_pkg::OQ_AW-1:0] oq_rptr_reg;
    logic                       oq_push;
    logic                       oq_pop;

    assign oq_push = s2_valid_reg && s2_emit_reg;
    assign oq_pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_data_reg[oq_wptr_reg] <= vmax;
            oq_last_reg[oq_wptr_reg] <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wptr_reg  <= '0;
            oq_rptr_reg  <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wptr_reg <= oq_wptr_reg + mp2d_pkg::OQ_AW'(1);
            if (oq_pop)
                oq_rptr_reg <= oq_rptr_reg + mp2d_pkg::OQ_AW'(1);
            oq_count_reg <= oq_count_reg + mp2d_pkg::OQ_CW'(oq_push)
                            - mp2d_pkg::OQ_CW'(oq_pop);
        end
    end

    assign m_axis_tvalid = oq_count_reg != '0;
    assign m_axis_tdata  = TDATA_W'(oq_data_reg[oq_rptr_reg]);
    assign m_axis_tlast  = oq_last_reg[oq_rptr_reg];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_push |-> ((oq_count_reg < mp2d_pkg::OQ_CW'(mp2d_pkg::OQ_DEPTH)) || oq_pop))
        else $error("output queue overflow");

    a_last_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_last_reg) |-> s1_emit_reg)
        else $error("last flag on a beat without a result");

    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !s_axis_tready)
        else $error("input taken right after a register write");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mp2d_pkg::ST_WALK) |->
            ((walk_col_reg <= col_reg) && (walk_row_reg <= row_reg)))
        else $error("phase rebuild walked past the stream position");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the streaming 2-D max pooling core.
module testbench;

    localparam int DW          = mp2d_pkg::DEF_DATA_WIDTH;
    localparam int MAX_H       = mp2d_pkg::DEF_MAX_HEIGHT;
    localparam int MAX_W       = mp2d_pkg::DEF_MAX_WIDTH;
    localparam int MAX_C       = mp2d_pkg::DEF_MAX_CHANNELS;
    localparam int MAX_K       = mp2d_pkg::DEF_MAX_WINDOW;
    localparam int IDX_W       = mp2d_pkg::CFG_INDEX_W;
    localparam int CFG_DW      = mp2d_pkg::CFG_DATA_W;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_GOAL = 1000;

    class pool_scoreboard;
        typedef struct {
            logic [DW-1:0] value;
            logic          last;
        } pooled_t;

        int unsigned height_reg, width_reg, chan_reg, win_reg, step_reg;
        int unsigned row_pos, col_pos, chan_pos;
        logic signed [DW-1:0] win_mem [MAX_K*MAX_C];
        logic signed [DW-1:0] line_mem [MAX_K*MAX_W*MAX_C];
        pooled_t pooled_q[$];
        int errors;
        int results;

        function new();
            height_reg = mp2d_pkg::RST_IMAGE_HEIGHT;
            width_reg  = mp2d_pkg::RST_IMAGE_WIDTH;
            chan_reg   = mp2d_pkg::RST_CHANNEL_COUNT;
            win_reg    = mp2d_pkg::RST_WINDOW_SIZE;
            step_reg   = mp2d_pkg::RST_STEP_SIZE;
            row_pos    = 0;
            col_pos    = 0;
            chan_pos   = 0;
            errors     = 0;
            results    = 0;
        endfunction

        static function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                mp2d_pkg::REG_IMAGE_HEIGHT:  height_reg = data[mp2d_pkg::HEIGHT_W-1:0];
                mp2d_pkg::REG_IMAGE_WIDTH:   width_reg  = data[mp2d_pkg::WIDTH_W-1:0];
                mp2d_pkg::REG_CHANNEL_COUNT: chan_reg   = data[mp2d_pkg::CHANNELS_W-1:0];
                mp2d_pkg::REG_WINDOW_SIZE:   win_reg    = data[mp2d_pkg::WINDOW_W-1:0];
                mp2d_pkg::REG_STEP_SIZE:     step_reg   = data[mp2d_pkg::STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // true when the next sample starts an image whatever frame_start says
        function bit at_image_start();
            return (row_pos == 0 && col_pos == 0 && chan_pos == 0)
                || row_pos >= clamp(height_reg, MAX_H)
                || col_pos >= clamp(width_reg, MAX_W)
                || chan_pos >= clamp(chan_reg, MAX_C);
        endfunction

        function void note_sample(logic signed [DW-1:0] x, logic frame_start);
            int unsigned h, w, c, k, s, r, col, ch;
            logic signed [DW-1:0] hmax, vmax;
            pooled_t pooled;
            h = clamp(height_reg, MAX_H);
            w = clamp(width_reg, MAX_W);
            c = clamp(chan_reg, MAX_C);
            k = clamp(win_reg, MAX_K);
            s = clamp(step_reg, MAX_K);
            if (frame_start || row_pos >= h || col_pos >= w || chan_pos >= c) begin
                row_pos  = 0;
                col_pos  = 0;
                chan_pos = 0;
            end
            r   = row_pos;
            col = col_pos;
            ch  = chan_pos;
            win_mem[(col % k) * MAX_C + ch] = x;
            if (col + 1 >= k) begin
                hmax = x;
                for (int i = 0; i < k; i++)
                    if (win_mem[i * MAX_C + ch] > hmax)
                        hmax = win_mem[i * MAX_C + ch];
                line_mem[((r % k) * MAX_W + col) * MAX_C + ch] = hmax;
                if (r + 1 >= k && (r + 1 - k) % s == 0 && (col + 1 - k) % s == 0) begin
                    vmax = hmax;
                    for (int i = 0; i < k; i++)
                        if (line_mem[(i * MAX_W + col) * MAX_C + ch] > vmax)
                            vmax = line_mem[(i * MAX_W + col) * MAX_C + ch];
                    pooled.value = vmax;
                    pooled.last  = (r == ((h - k) / s) * s + k - 1)
                                && (col == ((w - k) / s) * s + k - 1)
                                && (ch + 1 == c);
                    pooled_q.push_back(pooled);
                end
            end
            chan_pos = ch + 1;
            if (chan_pos >= c) begin
                chan_pos = 0;
                col_pos  = col + 1;
                if (col_pos >= w) begin
                    col_pos = 0;
                    row_pos = (r + 1 >= h) ? 0 : r + 1;
                end
            end
        endfunction

        function void check_result(logic [DW-1:0] value, logic last);
            pooled_t pooled;
            results++;
            if (pooled_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, value %0d last %0b", $time, $signed(value), last);
                return;
            end
            pooled = pooled_q.pop_front();
            if (value !== pooled.value) begin
                errors++;
                $display("%0t: pooled value expected %0d, actual %0d",
                         $time, $signed(pooled.value), $signed(value));
            end
            if (last !== pooled.last) begin
                errors++;
                $display("%0t: tlast expected %0b, actual %0b", $time, pooled.last, last);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // [15:0] sample_value
    logic [0:0]        s_axis_tuser;   // [0] frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // [15:0] pooled_value
    logic              m_axis_tlast;

    pool_scoreboard sb;
    bit tx_nostall;
    bit rx_nostall;
    int rx_wait;
    int idle_cycles;
    int samples_sent;
    int random_samples;
    int phase_count;

    max_pool_2d_stream_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: per beat draw a stall, then hold tready high
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (rx_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata[DW-1:0], m_axis_tlast);
            rx_wait = rx_nostall ? 0 : $urandom_range(0, 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic [DW-1:0] random_sample();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic send_sample(logic [DW-1:0] value, logic frame_start);
        int gap;
        gap = tx_nostall ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= frame_start;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_sample(value, frame_start);
        samples_sent++;
    endtask

    // stop the sample stream and let every pending result drain
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pooled_q.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int h, int w, int c, int k, int s);
        drain_results();
        write_register(mp2d_pkg::REG_IMAGE_HEIGHT, CFG_DW'(h));
        write_register(mp2d_pkg::REG_IMAGE_WIDTH, CFG_DW'(w));
        write_register(mp2d_pkg::REG_CHANNEL_COUNT, CFG_DW'(c));
        write_register(mp2d_pkg::REG_WINDOW_SIZE, CFG_DW'(k));
        write_register(mp2d_pkg::REG_STEP_SIZE, CFG_DW'(s));
        phase_count++;
        tx_nostall = ($urandom_range(0, 3) == 0);
        rx_nostall = ($urandom_range(0, 3) == 0);
    endtask

    // well-formed images with random content; a rare frame_start mid-image.
    // The first beat after a register change restarts the image unless the
    // position already starts an image, so window stores are never read stale.
    task automatic stream_samples(int count);
        bit start;
        logic fs;
        for (int n = 0; n < count; n++)
        begin
            start = sb.at_image_start();
            if (start)
                fs = 1'($urandom_range(0, 1));
            else if (n == 0)
                fs = 1'b1;
            else
                fs = ($urandom_range(0, 39) == 0);
            send_sample(random_sample(), fs);
            random_samples++;
        end
    endtask

    function automatic int pick_size(int hi_raw, int typical);
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(hi_raw / 2 + 1, hi_raw);
            default: return $urandom_range(1, typical);
        endcase
    endfunction

    initial
    begin
        logic [15:0] extremes [16];
        int h, w, c, k, s, img, count;
        sb             = new();
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        m_axis_tready  = 1'b0;
        rx_wait        = 0;
        idle_cycles    = 0;
        samples_sent   = 0;
        random_samples = 0;
        phase_count    = 0;
        tx_nostall     = 1'b0;
        rx_nostall     = 1'b0;
        extremes = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000,
                     16'h8000, 16'h8001, 16'h8000, 16'hFFFE,
                     16'h0001, 16'h7FFE, 16'hFFFF, 16'h7FFF,
                     16'h5555, 16'hAAAA, 16'h8000, 16'h8000};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // two rows, four columns, two channels: every window holds an extreme
        configure(2, 4, 2, 2, 2);
        for (int i = 0; i < 16; i++)
            send_sample(extremes[i], i == 0);
        // one row under a 2-wide window: never a result; wrap, then a restart
        configure(1, 3, 1, 2, 1);
        for (int i = 0; i < 6; i++)
            send_sample(extremes[15 - i], i == 4);

        while (random_samples < RANDOM_GOAL)
        begin
            case (phase_count)
                2: begin h = 511; w = 511; c = 31; k = 7; s = 7; end
                3: begin h = 0;   w = 0;   c = 0;  k = 0; s = 0; end
                4: begin h = 256; w = 256; c = 16; k = 4; s = 4; end
                default:
                begin
                    h = pick_size(511, 8);
                    w = pick_size(511, 8);
                    c = pick_size(31, 4);
                    k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
                    s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
                end
            endcase
            configure(h, w, c, k, s);
            img = pool_scoreboard::clamp(h, MAX_H) * pool_scoreboard::clamp(w, MAX_W)
                * pool_scoreboard::clamp(c, MAX_C);
            if (img <= 256)
                count = $urandom_range(1, 3) * img + $urandom_range(0, img - 1);
            else
                count = $urandom_range(20, 80);
            if (count > RANDOM_GOAL - random_samples)
                count = RANDOM_GOAL - random_samples;
            stream_samples(count);
        end

        drain_results();
        repeat (12) @(posedge clk);
        if (sb.pooled_q.size() > 0)
        begin
            sb.errors += sb.pooled_q.size();
            $display("%0t: %0d expected results never arrived", $time, sb.pooled_q.size());
        end
        $display("Streamed %0d samples over %0d register settings, %0d pooled beats checked.",
                 samples_sent, phase_count, sb.results);
        $display("Covered clamped register values, undersized images and frame restarts.");
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
